// File: sv/assert_macros.svh
// Shared assertion macros. All checks sample on clk and are off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication check: when ante holds, cons must hold on the same edge.
`define ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle check: when ante holds, cons must hold on the following edge.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: sv/usir_pkg.sv
`timescale 1ns / 1ps

package usir_pkg;

    // Table geometry
    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    // Lowest base for newly assigned ids
    localparam logic [15:0] ID_FLOOR = 16'd100;
    localparam logic [15:0] ID_MAX = 16'hFFFF;
    localparam logic [15:0] BUILTIN_LIMIT_RESET = 16'd26;

    typedef enum logic [2:0] {
        CMD_REGISTER     = 3'd0,
        CMD_UNREGISTER   = 3'd1,
        CMD_CHECK_CUSTOM = 3'd2,
        CMD_UUID_BY_ID   = 3'd3,
        CMD_ID_BY_UUID   = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_NOT_FOUND = 2'd1,
        STS_FULL      = 2'd2,
        STS_OVERFLOW  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FIN
    } state_t;

    // One stored table entry
    typedef struct packed {
        logic [63:0] uuid_upper;
        logic [63:0] uuid_lower;
        logic [15:0] service;
    } entry_t;

endpackage

// File: sv/usir_entry_ram.sv
`timescale 1ns / 1ps

// Entry store: one write port, one read port, registered read data.
module usir_entry_ram
    import usir_pkg::*;
(
    input  logic             clk,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  entry_t           wr_data,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    output entry_t           rd_data
);

    entry_t mem [TABLE_ENTRIES];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, registered read data
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: sv/uuid_service_id_registry_unit.sv
`timescale 1ns / 1ps

// Channel    Handshake            Payload
// request    in_valid/in_stall    command, uuid_upper, uuid_lower, service_number
// result     out_valid/out_stall  status, service_number_out, uuid_upper_out,
//                                 uuid_lower_out
// config     cfg_wr_en            cfg_wr_data (builtin_id_limit)
//
// Each request is accepted in ST_IDLE, walks the entry RAM through its single
// read port in ST_SCAN, and is resolved and written back in ST_FIN. A request
// is accepted while a previous result still waits in the output register; the
// resolve step waits only while that register is full and out_stall is high.
// Reset clears all valid bits at once and sets builtin_id_limit to 26; the entry
// RAM itself is not cleared.

`include "assert_macros.svh"

module uuid_service_id_registry_unit
    import usir_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  command,
    input  logic [63:0] uuid_upper,
    input  logic [63:0] uuid_lower,
    input  logic [15:0] service_number,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [15:0] service_number_out,
    output logic [63:0] uuid_upper_out,
    output logic [63:0] uuid_lower_out
);

    state_t state_reg, state_next;

    logic [15:0] limit_reg;
    logic [TABLE_ENTRIES-1:0] valid_reg;

    // Latched request
    logic [2:0]  cmd_reg;
    logic [63:0] hi_reg;
    logic [63:0] lo_reg;
    logic [15:0] sid_reg;

    // Scan control
    logic [CNT_W-1:0] cnt_reg;
    logic             pend_reg;
    logic [IDX_W-1:0] pend_idx_reg;

    // Scan accumulators
    logic             found_reg;
    logic [IDX_W-1:0] found_idx_reg;
    logic [15:0]      found_svc_reg;
    logic [63:0]      found_hi_reg;
    logic [63:0]      found_lo_reg;
    logic [15:0]      top_reg;
    logic             free_found_reg;
    logic [IDX_W-1:0] free_idx_reg;

    // Output register
    logic        out_valid_reg;
    logic [1:0]  out_status_reg;
    logic [15:0] out_id_reg;
    logic [63:0] out_hi_reg;
    logic [63:0] out_lo_reg;

    logic   accept;
    logic   rd_en;
    logic   fin_fire;
    entry_t rd_data;
    entry_t wr_data;
    logic   wr_en;
    logic   clr_en;
    logic   by_uuid;
    logic   ent_valid;
    logic   ent_match;

    logic [1:0]  res_status;
    logic [15:0] res_id;
    logic [63:0] res_hi;
    logic [63:0] res_lo;

    usir_entry_ram u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (free_idx_reg),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (cnt_reg[IDX_W-1:0]),
        .rd_data (rd_data)
    );

    assign accept = in_valid && !in_stall;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (cnt_reg == CNT_W'(TABLE_ENTRIES))
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // FSM outputs
    always_comb
    begin
        in_stall = 1'b1;
        rd_en    = 1'b0;
        fin_fire = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
            end
            ST_SCAN:
            begin
                rd_en = cnt_reg < CNT_W'(TABLE_ENTRIES);
            end
            ST_FIN:
            begin
                fin_fire = !out_valid_reg || !out_stall;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= BUILTIN_LIMIT_RESET;
        end
        else if (cfg_wr_en)
        begin
            limit_reg <= cfg_wr_data;
        end
    end

    // Request latch
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= command;
            hi_reg  <= uuid_upper;
            lo_reg  <= uuid_lower;
            sid_reg <= service_number;
        end
    end

    // Entry compare for the data coming back from the RAM
    assign by_uuid   = (cmd_reg == CMD_REGISTER) || (cmd_reg == CMD_ID_BY_UUID);
    assign ent_valid = pend_reg && valid_reg[pend_idx_reg];
    assign ent_match = ent_valid && (by_uuid
                       ? (rd_data.uuid_upper == hi_reg && rd_data.uuid_lower == lo_reg)
                       : (rd_data.service == sid_reg));

    // Scan counter and accumulators
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg        <= '0;
            pend_reg       <= 1'b0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            top_reg        <= ID_FLOOR;
        end
        else if (accept)
        begin
            cnt_reg        <= '0;
            pend_reg       <= 1'b0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            top_reg        <= ID_FLOOR;
        end
        else
        begin
            pend_reg <= rd_en;
            if (rd_en)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            if (ent_match && !found_reg)
            begin
                found_reg <= 1'b1;
            end
            if (ent_valid && rd_data.service > top_reg)
            begin
                top_reg <= rd_data.service;
            end
            if (pend_reg && !valid_reg[pend_idx_reg] && !free_found_reg)
            begin
                free_found_reg <= 1'b1;
            end
        end
    end

    // Accumulator payload
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            pend_idx_reg <= cnt_reg[IDX_W-1:0];
        end
        if (ent_match && !found_reg)
        begin
            found_idx_reg <= pend_idx_reg;
            found_svc_reg <= rd_data.service;
            found_hi_reg  <= rd_data.uuid_upper;
            found_lo_reg  <= rd_data.uuid_lower;
        end
        if (pend_reg && !valid_reg[pend_idx_reg] && !free_found_reg)
        begin
            free_idx_reg <= pend_idx_reg;
        end
    end

    // Resolve the command once the scan is complete
    always_comb
    begin
        res_status = STS_NOT_FOUND;
        res_id     = '0;
        res_hi     = '0;
        res_lo     = '0;
        wr_en      = 1'b0;
        clr_en     = 1'b0;
        wr_data.uuid_upper = hi_reg;
        wr_data.uuid_lower = lo_reg;
        wr_data.service    = top_reg + 16'd1;
        unique case (cmd_reg) inside
            CMD_REGISTER:
            begin
                if (found_reg)
                begin
                    res_status = STS_OK;
                    res_id     = found_svc_reg;
                end
                else if (!free_found_reg)
                begin
                    res_status = STS_FULL;
                end
                else if (top_reg == ID_MAX)
                begin
                    res_status = STS_OVERFLOW;
                end
                else
                begin
                    res_status = STS_OK;
                    res_id     = top_reg + 16'd1;
                    wr_en      = fin_fire;
                end
            end
            CMD_UNREGISTER:
            begin
                if (found_reg)
                begin
                    res_status = STS_OK;
                    res_id     = sid_reg;
                    clr_en     = fin_fire;
                end
            end
            CMD_CHECK_CUSTOM, CMD_UUID_BY_ID:
            begin
                if (found_reg && sid_reg >= limit_reg)
                begin
                    res_status = STS_OK;
                    res_id     = sid_reg;
                    if (cmd_reg == CMD_UUID_BY_ID)
                    begin
                        res_hi = found_hi_reg;
                        res_lo = found_lo_reg;
                    end
                end
            end
            CMD_ID_BY_UUID:
            begin
                if (found_reg)
                begin
                    res_status = STS_OK;
                    res_id     = found_svc_reg;
                end
            end
            default:
            begin
                res_status = STS_NOT_FOUND;
            end
        endcase
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[free_idx_reg] <= 1'b1;
            end
            if (clr_en)
            begin
                valid_reg[found_idx_reg] <= 1'b0;
            end
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fin_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin_fire)
        begin
            out_status_reg <= res_status;
            out_id_reg     <= res_id;
            out_hi_reg     <= res_hi;
            out_lo_reg     <= res_lo;
        end
    end

    assign out_valid          = out_valid_reg;
    assign status             = out_status_reg;
    assign service_number_out = out_id_reg;
    assign uuid_upper_out     = out_hi_reg;
    assign uuid_lower_out     = out_lo_reg;

    // Checks
    `ASSERT_IMPLIES(a_result_from_fin, $rose(out_valid_reg), $past(state_reg) == ST_FIN)
    `ASSERT_IMPLIES(a_fin_after_full_scan,
        state_reg == ST_FIN && $past(state_reg) == ST_SCAN,
        $past(cnt_reg) == CNT_W'(TABLE_ENTRIES))
    `ASSERT_IMPLIES(a_free_slot_empty, state_reg == ST_FIN && free_found_reg,
        !valid_reg[free_idx_reg])
    `ASSERT_IMPLIES(a_match_valid, state_reg == ST_FIN && found_reg,
        valid_reg[found_idx_reg])

endmodule
